// File: rtl/firlp_pkg.sv
// Package: shared types, constants and coefficient tables for the low-pass FIR.
`default_nettype none
package firlp_pkg;

  localparam int TAPS      = 16;
  localparam int SAMPLE_W  = 16;
  localparam int RESULT_W  = 24;
  localparam int OUT_SHIFT = 8;
  localparam int BIT_CNT_W = $clog2(SAMPLE_W);
  localparam int GROUP_N   = 4;
  localparam int GROUPS    = TAPS / GROUP_N;
  localparam int COEF_W    = 16;
  localparam int GSUM_W    = 16;
  localparam int BSUM_W    = GSUM_W + $clog2(GROUPS);
  localparam int ACC_H_W   = 19;
  localparam int SUM_W     = ACC_H_W + SAMPLE_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESULT_W-1:0] result_t;
  typedef logic [BSUM_W-1:0]          bsum_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fir_state_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic neg;
  } acc_ctl_t;

  function automatic logic [COEF_W-1:0] coef_at(input logic [3:0] idx);
    logic [COEF_W-1:0] c;
    case (idx)
      4'd0, 4'd15: c = 16'd1656;
      4'd1, 4'd14: c = 16'd2444;
      4'd2, 4'd13: c = 16'd3244;
      4'd3, 4'd12: c = 16'd4008;
      4'd4, 4'd11: c = 16'd4692;
      4'd5, 4'd10: c = 16'd5244;
      4'd6, 4'd9:  c = 16'd5636;
      4'd7, 4'd8:  c = 16'd5840;
      default:     c = 16'd0;
    endcase
    return c;
  endfunction

  function automatic logic [GSUM_W-1:0] group_sum(input logic [1:0] grp,
                                                 input logic [GROUP_N-1:0] pat);
    logic [GSUM_W-1:0] s;
    s = '0;
    for (int k = 0; k < GROUP_N; k++) begin
      if (pat[k]) begin
        s = s + coef_at({grp, 2'(k)});
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/firlp_if.sv
// Interfaces: sample request channel and filtered result channel.
`default_nettype none
interface firlp_in_if;
  import firlp_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface firlp_out_if;
  import firlp_pkg::*;
  logic    valid;
  logic    ready;
  result_t filtered_out;
  modport source (output valid, output filtered_out, input ready);
  modport sink (input valid, input filtered_out, output ready);
endinterface
`default_nettype wire

// File: rtl/firlp_tap_line.sv
// Tap line: sample delay line plus per-tap bit-serial shift registers.
`default_nettype none
module firlp_tap_line
  import firlp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic            shift_en,
  input  wire sample_t         sample_in,
  output logic [TAPS-1:0]      tap_bits
);

  sample_t             taps_r [TAPS];
  logic [SAMPLE_W-1:0] work_r [TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        taps_r[i] <= '0;
      end
    end else if (load) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        taps_r[i] <= taps_r[i+1];
      end
      taps_r[TAPS-1] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        work_r[i] <= taps_r[i+1];
      end
      work_r[TAPS-1] <= sample_in;
    end else if (shift_en) begin
      for (int i = 0; i < TAPS; i++) begin
        work_r[i] <= {1'b0, work_r[i][SAMPLE_W-1:1]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      tap_bits[i] = work_r[i][0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/firlp_da_acc.sv
// Distributed-arithmetic bit-plane sum and LSB-first serial accumulator.
`default_nettype none
module firlp_da_acc
  import firlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire acc_ctl_t    ctl,
  input  wire [TAPS-1:0]   tap_bits,
  output result_t          result
);

  bsum_t                     s_r;
  bsum_t                     s_nxt;
  logic                      s_valid_r;
  logic                      s_neg_r;
  logic signed [ACC_H_W-1:0] h_r;
  logic signed [ACC_H_W-1:0] h_nxt;
  logic signed [ACC_H_W-1:0] s_ext;
  logic signed [ACC_H_W-1:0] t;
  logic [SAMPLE_W-1:0]       low_r;
  logic signed [SUM_W-1:0]   full_sum;
  logic signed [SUM_W-1:0]   shifted;

  always_comb begin
    s_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      s_nxt = s_nxt + BSUM_W'(group_sum(2'(g), tap_bits[g*GROUP_N +: GROUP_N]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      s_r     <= s_nxt;
      s_neg_r <= ctl.neg;
    end
  end

  always_comb begin
    s_ext = signed'(ACC_H_W'(s_r));
    t     = s_neg_r ? (h_r - s_ext) : (h_r + s_ext);
    h_nxt = t >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
    end else if (ctl.clear) begin
      h_r <= '0;
    end else if (s_valid_r) begin
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid_r) begin
      low_r <= {t[0], low_r[SAMPLE_W-1:1]};
    end
  end

  always_comb begin
    full_sum = signed'({h_r, low_r});
    shifted  = full_sum >>> OUT_SHIFT;
    result   = shifted[RESULT_W-1:0];
  end

endmodule
`default_nettype wire

// File: rtl/fir_lowpass_16_tap.sv
// Top level: 16-tap low-pass FIR with bit-serial distributed-arithmetic datapath.
//
// Usage:
//   in_if  (sink)   : one signed 16-bit sample per request, taken when valid and ready.
//   out_if (source) : one signed 24-bit filtered result per request, same order.
//   Each sample enters a 16-deep delay line; the result is the sum of the taps,
//   oldest first, times a fixed symmetric coefficient set, shifted right by 8.
//   Datapath: the 16 sample bits are walked one per cycle through a shared
//   bit-plane adder and serial accumulator, followed by the adder pipeline
//   register, the drain state for the last accumulation, and the done state
//   that hands the sum to the output.
//   The finished result sits in an output register, so the next request is
//   taken as the current result is handed over.
//   Stall: if out_if is still holding an unread result when the next one is
//   done, the block holds that result internally and drops in_if.ready.
//   Reset: synchronous on rst_n low; clears the delay line to zero, the
//   control state and the output valid flag.
`default_nettype none
module fir_lowpass_16_tap
  import firlp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  firlp_in_if.sink     in_if,
  firlp_out_if.source  out_if
);

  fir_state_t           state_r;
  fir_state_t           state_nxt;
  logic [BIT_CNT_W-1:0] cnt_r;
  logic [BIT_CNT_W-1:0] cnt_nxt;
  logic                 out_valid_r;
  result_t              out_data_r;
  logic                 out_free;
  logic                 in_ready;
  logic                 accept;
  logic                 load_out;
  logic                 shift_en;
  acc_ctl_t             acc_ctl;
  logic [TAPS-1:0]      tap_bits;
  result_t              acc_result;

  localparam logic [BIT_CNT_W-1:0] LastBit = BIT_CNT_W'(SAMPLE_W - 1);

  firlp_tap_line u_tap_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .shift_en  (shift_en),
    .sample_in (in_if.sample_in),
    .tap_bits  (tap_bits)
  );

  firlp_da_acc u_da_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .tap_bits (tap_bits),
    .result   (acc_result)
  );

  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    load_out    = 1'b0;
    shift_en    = 1'b0;
    acc_ctl     = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RUN: begin
        shift_en    = 1'b1;
        acc_ctl.step = 1'b1;
        acc_ctl.neg  = (cnt_r == LastBit);
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LastBit) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        in_ready = out_free;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    accept        = in_if.valid && in_ready;
    acc_ctl.clear = accept;
    if (accept) begin
      state_nxt = ST_RUN;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= acc_result;
    end
  end

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid_r;
  assign out_if.filtered_out = out_data_r;

`ifndef SYNTH
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (state_r == ST_RUN) && (cnt_r == '0))
    else $error("request accepted but bit-serial run did not start");

  a_run_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == LastBit) |=> (state_r == ST_DRAIN))
    else $error("last bit of run not followed by drain");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) || (state_r == ST_DRAIN) |-> !in_if.ready)
    else $error("input ready while datapath busy");

  a_blocked_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_if.ready
      |=> (state_r == ST_DONE) && $stable(out_data_r))
    else $error("finished result not held while output stalled");
`endif

endmodule
`default_nettype wire

// File: verif/tb_fir_lowpass_16_tap.sv
// Testbench for the 16-tap low-pass FIR: self-predicting scoreboard with randomized flow control.
`timescale 1ns / 1ps
module tb_fir_lowpass_16_tap;
  import firlp_pkg::*;

  class lowpass_scoreboard;
    int      coef_tab[TAPS] = '{1656, 2444, 3244, 4008, 4692, 5244, 5636, 5840,
                                5840, 5636, 5244, 4692, 4008, 3244, 2444, 1656};
    sample_t history[TAPS] = '{default: '0};
    logic [3:0] head = '0;
    result_t filtered_expected_q[$];
    int      mismatches = 0;
    int      samples_seen = 0;
    int      results_seen = 0;

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task note_sample(input sample_t s);
      longint     acc;
      logic [3:0] rd;
      history[head] = s;
      acc = 0;
      rd = head + 4'd1;
      for (int i = 0; i < TAPS; i++) begin
        acc += longint'(coef_tab[i]) * longint'(history[rd]);
        rd++;
      end
      head++;
      filtered_expected_q.push_back(result_t'(acc >>> OUT_SHIFT));
      samples_seen++;
    endtask

    task check_filtered(input result_t got);
      result_t want;
      if (filtered_expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected (%0d)",
                                  results_seen, got));
      end else begin
        want = filtered_expected_q.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("result %0d filtered_out got %0d expected %0d",
                                    results_seen, got, want));
        end
      end
      results_seen++;
    endtask

    task check_drained();
      if (filtered_expected_q.size() != 0) begin
        report_mismatch($sformatf("%0d expected results never arrived",
                                  filtered_expected_q.size()));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   drain_wait;

  lowpass_scoreboard sb = new;

  firlp_in_if  in_ch();
  firlp_out_if out_ch();

  fir_lowpass_16_tap u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_filtered(out_ch.filtered_out);
      end
    end
  end

  initial begin
    #10ms;
    $display("Timeout waiting for the filter");
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  function automatic sample_t random_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      return sample_t'($urandom);
    end else if (sel < 78) begin
      return sample_t'(int'($urandom_range(512)) - 256);
    end else begin
      case ($urandom_range(4))
        0:       return sample_t'(16'h7FFF);
        1:       return sample_t'(16'h8000);
        2:       return sample_t'(16'hFFFF);
        3:       return sample_t'(16'h0001);
        default: return sample_t'(16'h0000);
      endcase
    end
  endfunction

  // mix random samples with full-scale runs long enough to fill the delay line
  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    int      burst_left;
    sample_t burst_val;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    burst_left     = 0;
    for (int k = 0; k < n; k++) begin
      if (burst_left == 0 && $urandom_range(99) < 4) begin
        burst_left = $urandom_range(20, 16);
        burst_val  = $urandom_range(1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
      end
      if (burst_left > 0) begin
        burst_left--;
        send_sample(burst_val);
      end else begin
        send_sample(random_sample());
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // impulse and single extremes against a cleared history, then a full-scale run
    send_sample(sample_t'(16'h0001));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'hFFFF));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));
    send_sample(sample_t'(16'h0000));
    repeat (16) send_sample(sample_t'(16'h7FFF));

    run_phase(275, 0, 0);
    run_phase(275, 58, 0);
    run_phase(275, 0, 58);
    run_phase(275, 17, 17);
    in_ch.valid <= 1'b0;

    drain_wait = 0;
    while (sb.filtered_expected_q.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (25) @(posedge clk);
    sb.check_drained();

    $display("Filtered %0d samples into %0d results across four flow-control phases",
             sb.samples_seen, sb.results_seen);
    $display("(free running, input gaps, output stalls, both), %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/firlp_pkg.sv
rtl/firlp_if.sv
rtl/firlp_tap_line.sv
rtl/firlp_da_acc.sv
rtl/fir_lowpass_16_tap.sv
verif/tb_fir_lowpass_16_tap.sv
